>>> hdl/ket_pkg.sv
// Shared constants, codes and control structs for the keyed entry table.
package ket_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int CMD_W    = 2;
   localparam int STS_W    = 3;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STS_W-1:0] STS_INSERTED = 3'd0;
   localparam logic [STS_W-1:0] STS_LISTED   = 3'd1;
   localparam logic [STS_W-1:0] STS_DELETED  = 3'd2;
   localparam logic [STS_W-1:0] STS_MISSING  = 3'd3;
   localparam logic [STS_W-1:0] STS_FOUND    = 3'd4;
   localparam logic [STS_W-1:0] STS_FULL     = 3'd5;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ket_ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic scan_last;
   } ket_sts_type;

endpackage

>>> hdl/keyed_entry_table.sv
// Top level of the keyed entry table: insert, delete and search by key.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   request   req_command, req_key, req_value         start high while busy low
//   result    rsp_status                              rsp_strobe, one cycle
//
// Each request passes through one load, a scan that reads all CAPACITY
// entries of the key store (one read port, one entry a cycle), a drain of
// the compare stage and one commit before the next request can be taken.
// The status word is on rsp_status for one cycle with rsp_strobe,
// the cycle after commit, and busy is already low in that cycle.
// Reset is synchronous and clears every valid bit at once; no clearing pass.
// The receiver cannot stall: the status word is shown once and then dropped.
module keyed_entry_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ket_pkg::CMD_W-1:0]          req_command,
   input  logic signed [ket_pkg::KEY_W-1:0]   req_key,
   input  logic [ket_pkg::VAL_W-1:0]          req_value,
   output logic                               rsp_strobe,
   output logic [ket_pkg::STS_W-1:0]          rsp_status
);

   // command and status between the sequencer and the datapath
   ket_pkg::ket_ctl_type ctl;
   ket_pkg::ket_sts_type sts;

   // sequencer: hold busy from accept to commit, strobe the status word
   ket_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctl        (ctl),
      .sts        (sts)
   );

   // datapath: scan the store, track first hit and first free entry, commit
   ket_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .req_command (req_command),
      .req_key     (req_key),
      .req_value   (req_value),
      .rsp_status  (rsp_status)
   );

endmodule

>>> hdl/ket_datapath.sv
// Datapath: key and value store, valid bits, scan counter, compare and status.
module ket_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  ket_pkg::ket_ctl_type        ctl,
   output ket_pkg::ket_sts_type        sts,
   input  logic [ket_pkg::CMD_W-1:0]   req_command,
   input  logic signed [ket_pkg::KEY_W-1:0] req_key,
   input  logic [ket_pkg::VAL_W-1:0]   req_value,
   output logic [ket_pkg::STS_W-1:0]   rsp_status
);

   logic [ket_pkg::KEY_W-1:0] key_mem [ket_pkg::CAPACITY];
   logic [ket_pkg::VAL_W-1:0] val_mem [ket_pkg::CAPACITY];

   logic [ket_pkg::CAPACITY-1:0] valid_ff, valid_in;

   logic [ket_pkg::CMD_W-1:0] cmd_ff;
   logic [ket_pkg::KEY_W-1:0] key_ff;
   logic [ket_pkg::VAL_W-1:0] val_ff;

   logic [ket_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [ket_pkg::KEY_W-1:0] rd_key_ff;
   logic [ket_pkg::IDX_W-1:0] cmp_idx_ff;
   logic                      cmp_vld_ff, cmp_vld_in;

   logic                      hit_ff, hit_in;
   logic [ket_pkg::IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic                      free_ff, free_in;
   logic [ket_pkg::IDX_W-1:0] free_idx_ff, free_idx_in;

   logic [ket_pkg::STS_W-1:0] status_ff, status_in;
   logic                      do_write;

   assign sts.scan_last = (idx_ff == ket_pkg::IDX_LAST);
   assign rsp_status    = status_ff;

   // compare stage and next-state logic
   always_comb begin
      logic cur_valid;
      cur_valid   = valid_ff[cmp_idx_ff];
      idx_in      = idx_ff;
      cmp_vld_in  = ctl.scan;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      valid_in    = valid_ff;
      status_in   = status_ff;
      do_write    = 1'b0;

      if (ctl.load) begin
         idx_in  = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (ctl.scan) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmp_vld_ff) begin
         if (cur_valid && (rd_key_ff == key_ff) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (!cur_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      if (ctl.commit) begin
         unique case (cmd_ff)
            ket_pkg::CMD_INSERT: begin
               if (hit_ff) begin
                  status_in = ket_pkg::STS_LISTED;
               end else if (free_ff) begin
                  status_in             = ket_pkg::STS_INSERTED;
                  valid_in[free_idx_ff] = 1'b1;
                  do_write              = 1'b1;
               end else begin
                  status_in = ket_pkg::STS_FULL;
               end
            end
            ket_pkg::CMD_DELETE: begin
               if (hit_ff) begin
                  status_in            = ket_pkg::STS_DELETED;
                  valid_in[hit_idx_ff] = 1'b0;
               end else begin
                  status_in = ket_pkg::STS_MISSING;
               end
            end
            ket_pkg::CMD_SEARCH: begin
               status_in = hit_ff ? ket_pkg::STS_FOUND : ket_pkg::STS_MISSING;
            end
            default: begin
               status_in = ket_pkg::STS_MISSING;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         idx_ff     <= '0;
      end else begin
         valid_ff   <= valid_in;
         cmp_vld_ff <= cmp_vld_in;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
         idx_ff     <= idx_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_command;
         key_ff <= $unsigned(req_key);
         val_ff <= req_value;
      end
      cmp_idx_ff  <= idx_ff;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
   end

   // entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         key_mem[free_idx_ff] <= key_ff;
         val_mem[free_idx_ff] <= val_ff;
      end
      rd_key_ff <= key_mem[idx_ff];
   end

`ifndef SYNTHESIS
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (ctl.commit && hit_ff) |-> valid_ff[hit_idx_ff])
      else $error("hit entry not valid at commit");

   a_free_empty: assert property (@(posedge clock) disable iff (reset)
      (ctl.commit && free_ff) |-> !valid_ff[free_idx_ff])
      else $error("free entry already valid at commit");

   a_no_cmp_at_commit: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> !cmp_vld_ff)
      else $error("compare still in flight at commit");
`endif

endmodule

>>> hdl/ket_controller.sv
// Controller: sequences load, scan, drain and commit for each request.
module ket_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output ket_pkg::ket_ctl_type ctl,
   input  ket_pkg::ket_sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   assign ctl.load   = (state_ff == ST_IDLE) && start;
   assign ctl.scan   = (state_ff == ST_SCAN);
   assign ctl.commit = (state_ff == ST_COMMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_SCAN;
                  busy_ff  <= 1'b1;
               end
            end
            ST_SCAN: begin
               if (sts.scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("two strobes in a row");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && start) |=> (busy_ff && (state_ff == ST_SCAN)))
      else $error("accepted request did not raise busy");

   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (state_ff == ST_IDLE))
      else $error("not busy outside idle");
`endif

endmodule
